>>> rtl/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg: shared types and constants for the array list engine
// Holds the request and result structs, the request and status codes, the
// widths that follow from the list capacity and the fixed field widths.
// ----------------------------------------------------------------------------
package ale_pkg;

  // List capacity and the widths derived from it.
  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the request and result.
  localparam int REQ_W   = 3;
  localparam int WORD_W  = 64;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 3;
  localparam int FIDX_W  = 5;
  localparam int FCNT_W  = 6;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DUMP   = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd4;

  // One incoming request.
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [WORD_W-1:0] entry_word;
    logic [POS_W-1:0]  position;
  } cmd_t;

  // One outgoing result.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FIDX_W-1:0] found_index;
    logic [WORD_W-1:0] dump_word;
    logic [FCNT_W-1:0] entry_count;
    logic              last;
  } rsp_t;

endpackage

>>> rtl/ale_ram.sv
// ----------------------------------------------------------------------------
// ale_ram: simple dual-port synchronous RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module ale_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/array_list_engine.sv
// Append, failed checks and unknown requests answer in the cycle after the
// request; an insert or delete that moves entries walks the list first, search
// reads entries until a match or the last entry, and a dump streams count
// results, one a cycle, from index 0 up.
// An insert or delete walk reads one entry and writes one per cycle; results
// cannot be stalled. No new request is taken while busy. Reset clears the control registers only.
// ----------------------------------------------------------------------------
// array_list_engine: ordered list of record words with insert/delete/search
// A sequencer walks the list RAM to shift entries, search for a word or dump
// the whole list, and reports one strobed result per step that ends.
// ----------------------------------------------------------------------------
module array_list_engine
  import ale_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output rsp_t result,
  output logic result_valid
);

  localparam int CMP_W = (CNT_W > POS_W ? CNT_W : POS_W) + 1;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_DUMP = 3'd4;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  ptr, ptr_next;
  logic              rd_on, rd_on_next;
  logic              pend, pend_next;
  logic [IDX_W-1:0]  pend_addr, pend_addr_next;
  logic [IDX_W-1:0]  last_idx, last_idx_next;
  logic [IDX_W-1:0]  pos_q, pos_q_next;
  logic [WORD_W-1:0] word_q, word_q_next;
  rsp_t              result_next;
  logic              result_valid_next;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata;

  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  cnt_x;
  logic              is_full;
  logic              is_empty;
  logic              stop_rd;

  ale_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr),
    .rdata (rdata)
  );

  assign busy     = (state != S_IDLE);
  assign pos_x    = CMP_W'(cmd.position);
  assign cnt_x    = CMP_W'(count);
  assign is_full  = (cnt_x == CMP_W'(CAPACITY));
  assign is_empty = (count == '0);

  // The read walk stops at the position for insert, at the last entry otherwise.
  assign stop_rd = (state == S_INS) ? (ptr == pos_q) : (ptr == last_idx);

  // Sequencer: request decode, RAM walk and result formation.
  always_comb begin
    state_next        = state;
    count_next        = count;
    ptr_next          = ptr;
    rd_on_next        = rd_on;
    pend_next         = 1'b0;
    pend_addr_next    = pend_addr;
    last_idx_next     = last_idx;
    pos_q_next        = pos_q;
    word_q_next       = word_q;
    result_valid_next = 1'b0;
    result_next       = '0;
    we                = 1'b0;
    waddr             = pend_addr;
    wdata             = rdata;

    if (state == S_IDLE) begin
      if (start) begin
        result_valid_next = 1'b1;
        result_next.last  = 1'b1;
        word_q_next       = cmd.entry_word;
        pos_q_next        = IDX_W'(cmd.position);
        last_idx_next     = IDX_W'(count - CNT_W'(1));
        case (cmd.req_type)
          REQ_APPEND: begin
            if (is_full) begin
              result_next.status = ST_FULL;
            end else begin
              we         = 1'b1;
              waddr      = IDX_W'(count);
              wdata      = cmd.entry_word;
              count_next = count + CNT_W'(1);
            end
          end
          REQ_INSERT: begin
            if (is_full) begin
              result_next.status = ST_FULL;
            end else if (pos_x > cnt_x) begin
              result_next.status = ST_BAD_POS;
            end else if (pos_x == cnt_x) begin
              we         = 1'b1;
              waddr      = IDX_W'(cmd.position);
              wdata      = cmd.entry_word;
              count_next = count + CNT_W'(1);
            end else begin
              result_valid_next = 1'b0;
              state_next        = S_INS;
              ptr_next          = IDX_W'(count - CNT_W'(1));
              rd_on_next        = 1'b1;
            end
          end
          REQ_SEARCH: begin
            if (is_empty) begin
              result_next.status = ST_EMPTY;
            end else begin
              result_valid_next = 1'b0;
              state_next        = S_SRCH;
              ptr_next          = '0;
              rd_on_next        = 1'b1;
            end
          end
          REQ_DELETE: begin
            if (is_empty) begin
              result_next.status = ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
              result_next.status = ST_NOT_FOUND;
            end else if (pos_x == cnt_x - CMP_W'(1)) begin
              count_next = count - CNT_W'(1);
            end else begin
              result_valid_next = 1'b0;
              state_next        = S_DEL;
              ptr_next          = IDX_W'(cmd.position) + IDX_W'(1);
              rd_on_next        = 1'b1;
            end
          end
          REQ_DUMP: begin
            if (is_empty) begin
              result_next.status = ST_EMPTY;
            end else begin
              result_valid_next = 1'b0;
              state_next        = S_DUMP;
              ptr_next          = '0;
              rd_on_next        = 1'b1;
            end
          end
          default: begin
            result_next.status = ST_OK;
          end
        endcase
      end
    end else begin
      // Issue the next read; its data is handled in the following cycle.
      if (rd_on) begin
        pend_next      = 1'b1;
        pend_addr_next = ptr;
        if (stop_rd) begin
          rd_on_next = 1'b0;
        end else if (state == S_INS) begin
          ptr_next = ptr - IDX_W'(1);
        end else begin
          ptr_next = ptr + IDX_W'(1);
        end
      end

      // Consume the data of the previous read.
      case (state)
        S_INS: begin
          if (pend) begin
            we    = 1'b1;
            waddr = pend_addr + IDX_W'(1);
          end else if (!rd_on) begin
            we                = 1'b1;
            waddr             = pos_q;
            wdata             = word_q;
            count_next        = count + CNT_W'(1);
            state_next        = S_IDLE;
            result_valid_next = 1'b1;
            result_next.last  = 1'b1;
          end
        end
        S_DEL: begin
          if (pend) begin
            we    = 1'b1;
            waddr = pend_addr - IDX_W'(1);
          end else if (!rd_on) begin
            count_next        = count - CNT_W'(1);
            state_next        = S_IDLE;
            result_valid_next = 1'b1;
            result_next.last  = 1'b1;
          end
        end
        S_SRCH: begin
          if (pend) begin
            if (rdata == word_q) begin
              result_valid_next       = 1'b1;
              result_next.last        = 1'b1;
              result_next.found_index = FIDX_W'(pend_addr);
              state_next              = S_IDLE;
              rd_on_next              = 1'b0;
              pend_next               = 1'b0;
            end else if (pend_addr == last_idx) begin
              result_valid_next  = 1'b1;
              result_next.last   = 1'b1;
              result_next.status = ST_NOT_FOUND;
              state_next         = S_IDLE;
            end
          end
        end
        S_DUMP: begin
          if (pend) begin
            result_valid_next       = 1'b1;
            result_next.found_index = FIDX_W'(pend_addr);
            result_next.dump_word   = rdata;
            if (pend_addr == last_idx) begin
              result_next.last = 1'b1;
              state_next       = S_IDLE;
            end
          end
        end
        default: begin
          state_next = S_IDLE;
          rd_on_next = 1'b0;
        end
      endcase
    end

    result_next.entry_count = FCNT_W'(count_next);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      rd_on        <= 1'b0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      rd_on        <= rd_on_next;
      pend         <= pend_next;
      result_valid <= result_valid_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    pend_addr <= pend_addr_next;
    last_idx  <= last_idx_next;
    pos_q     <= pos_q_next;
    word_q    <= word_q_next;
    result    <= result_next;
  end

  // The entry count never passes the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // A result that is not the last one belongs to a dump that is still running.
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> state == S_DUMP)
    else $error("non-final result outside a dump");

  // A successful append grows the list by exactly one.
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.req_type == REQ_APPEND && !is_full
    |=> count == $past(count) + CNT_W'(1))
    else $error("append did not grow the list");

  // During a walk the RAM never writes the entry that is being read.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    busy && rd_on && we |-> waddr != ptr)
    else $error("RAM read and write hit the same entry");

  // A walk in progress keeps the engine busy, so no request is taken.
  a_walk_blocks: assert property (@(posedge clk) disable iff (rst)
    (rd_on || pend) |-> busy)
    else $error("walk active while idle");

endmodule
